@@ hw/rtl/necir_pkg.sv @@
// ----------------------------------------------------------------------------
// necir_pkg
// Types, register indexes, reset values and window compare for the NEC IR
// frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

   localparam int unsigned DUR_W    = 15;
   localparam int unsigned MARGIN_W = 12;
   localparam int unsigned FIELD_W  = 16;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MARGIN       = 3'd0,
      CSR_LEADER_MARK  = 3'd1,
      CSR_LEADER_SPACE = 3'd2,
      CSR_REPEAT_SPACE = 3'd3,
      CSR_BIT_MARK     = 3'd4,
      CSR_ZERO_SPACE   = 3'd5,
      CSR_ONE_SPACE    = 3'd6
   } csr_index_type;

   localparam logic [MARGIN_W-1:0] RST_MARGIN       = 12'd200;
   localparam logic [DUR_W-1:0]    RST_LEADER_MARK  = 15'd9000;
   localparam logic [DUR_W-1:0]    RST_LEADER_SPACE = 15'd4500;
   localparam logic [DUR_W-1:0]    RST_REPEAT_SPACE = 15'd2250;
   localparam logic [DUR_W-1:0]    RST_BIT_MARK     = 15'd560;
   localparam logic [DUR_W-1:0]    RST_ZERO_SPACE   = 15'd560;
   localparam logic [DUR_W-1:0]    RST_ONE_SPACE    = 15'd1690;

   typedef enum logic [1:0] {
      ST_FRAME  = 2'd0,
      ST_REPEAT = 2'd1,
      ST_ERROR  = 2'd2
   } status_type;

   typedef enum logic {
      FS_IDLE   = 1'b0,
      FS_ACTIVE = 1'b1
   } frame_state_type;

   typedef struct packed {
      logic [DUR_W-1:0] mark_duration;
      logic [DUR_W-1:0] space_duration;
      logic             burst_start;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] address;
      logic [FIELD_W-1:0] command;
   } rsp_type;

   typedef struct packed {
      logic [MARGIN_W-1:0] tolerance_margin;
      logic [DUR_W-1:0]    leader_mark;
      logic [DUR_W-1:0]    leader_space;
      logic [DUR_W-1:0]    repeat_space;
      logic [DUR_W-1:0]    bit_mark;
      logic [DUR_W-1:0]    zero_space;
      logic [DUR_W-1:0]    one_space;
   } cfg_type;

   typedef struct packed {
      logic leader;
      logic rpt_code;
      logic one;
      logic zero;
   } sym_class_type;

   typedef struct packed {
      logic    emit;
      rsp_type rsp;
   } frame_out_type;

   function automatic logic in_window(input logic [DUR_W-1:0]    dur,
                                      input logic [DUR_W-1:0]    nominal,
                                      input logic [MARGIN_W-1:0] margin);
      logic [DUR_W-1:0] lo;
      logic [DUR_W:0]   hi;
      lo = (nominal > DUR_W'(margin)) ? nominal - DUR_W'(margin) : '0;
      hi = {1'b0, nominal} + (DUR_W + 1)'(margin);
      return ({1'b0, dur} < hi) && (dur > lo);
   endfunction

endpackage

@@ hw/rtl/necir_symbol_class.sv @@
// ----------------------------------------------------------------------------
// necir_symbol_class
// Window compares of one symbol against leader, repeat, one and zero codes.
// ----------------------------------------------------------------------------
module necir_symbol_class (
   input  necir_pkg::cfg_type       cfg,
   input  necir_pkg::req_type       sym,
   output necir_pkg::sym_class_type cls
);
   import necir_pkg::*;

   logic mark_leader;
   logic mark_bit;

   assign mark_leader = in_window(sym.mark_duration, cfg.leader_mark, cfg.tolerance_margin);
   assign mark_bit    = in_window(sym.mark_duration, cfg.bit_mark, cfg.tolerance_margin);

   assign cls.leader   = mark_leader &&
                         in_window(sym.space_duration, cfg.leader_space, cfg.tolerance_margin);
   assign cls.rpt_code = mark_leader &&
                         in_window(sym.space_duration, cfg.repeat_space, cfg.tolerance_margin);
   assign cls.one      = mark_bit &&
                         in_window(sym.space_duration, cfg.one_space, cfg.tolerance_margin);
   assign cls.zero     = mark_bit &&
                         in_window(sym.space_duration, cfg.zero_space, cfg.tolerance_margin);

endmodule

@@ hw/rtl/necir_frame_ctrl.sv @@
// ----------------------------------------------------------------------------
// necir_frame_ctrl
// Frame state, bit counter and payload shift register; forms the result.
// ----------------------------------------------------------------------------
module necir_frame_ctrl #(
   parameter int unsigned FIELD_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     burst_start,
   input  necir_pkg::sym_class_type cls,
   output necir_pkg::frame_out_type fout
);
   import necir_pkg::*;

   localparam int unsigned PAYLOAD_BITS = 2 * FIELD_BITS;
   localparam int unsigned CNT_W = $clog2(PAYLOAD_BITS);
   localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(PAYLOAD_BITS - 1);

   frame_state_type         state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [PAYLOAD_BITS-1:0] shift_ff, shift_in;
   logic [PAYLOAD_BITS-1:0] shifted;

   assign shifted = {cls.one, shift_ff[PAYLOAD_BITS-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      shift_in         = shift_ff;
      fout.emit        = 1'b0;
      fout.rsp.status  = ST_ERROR;
      fout.rsp.address = '0;
      fout.rsp.command = '0;
      if (step) begin
         if (burst_start) begin
            count_in = '0;
            if (cls.leader) begin
               state_in = FS_ACTIVE;
            end else begin
               state_in        = FS_IDLE;
               fout.emit       = 1'b1;
               fout.rsp.status = cls.rpt_code ? ST_REPEAT : ST_ERROR;
            end
         end else begin
            unique case (state_ff)
               FS_IDLE: begin
               end
               FS_ACTIVE: begin
                  if (!cls.one && !cls.zero) begin
                     state_in  = FS_IDLE;
                     count_in  = '0;
                     fout.emit = 1'b1;
                  end else begin
                     shift_in = shifted;
                     if (count_ff == LAST_BIT) begin
                        state_in         = FS_IDLE;
                        count_in         = '0;
                        fout.emit        = 1'b1;
                        fout.rsp.status  = ST_FRAME;
                        fout.rsp.address = FIELD_W'(shifted[FIELD_BITS-1:0]);
                        fout.rsp.command = FIELD_W'(shifted[PAYLOAD_BITS-1:FIELD_BITS]);
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

@@ hw/rtl/nec_ir_frame_decoder.sv @@
// A symbol is held in the symbol register; its result in the result register.
// Throughput: one symbol per cycle; the symbol register and the result
// register each take a new beat whenever the result side is free.
// Reset: synchronous, active high; registers return to their nominal NEC
// timings, the frame goes idle and no result is pending.
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC IR decoder: classifies mark/space symbols and assembles 32-bit frames.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder #(
   parameter int unsigned FIELD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  necir_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output necir_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_we,
   input  logic [necir_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [necir_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import necir_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          sym_valid_ff, sym_valid_in;
   req_type       sym_ff, sym_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          out_free;
   logic          sym_fire;
   sym_class_type cls;
   frame_out_type fout;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MARGIN:       cfg_in.tolerance_margin = csr_wdata[MARGIN_W-1:0];
            CSR_LEADER_MARK:  cfg_in.leader_mark      = csr_wdata[DUR_W-1:0];
            CSR_LEADER_SPACE: cfg_in.leader_space     = csr_wdata[DUR_W-1:0];
            CSR_REPEAT_SPACE: cfg_in.repeat_space     = csr_wdata[DUR_W-1:0];
            CSR_BIT_MARK:     cfg_in.bit_mark         = csr_wdata[DUR_W-1:0];
            CSR_ZERO_SPACE:   cfg_in.zero_space       = csr_wdata[DUR_W-1:0];
            CSR_ONE_SPACE:    cfg_in.one_space        = csr_wdata[DUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance_margin <= RST_MARGIN;
         cfg_ff.leader_mark      <= RST_LEADER_MARK;
         cfg_ff.leader_space     <= RST_LEADER_SPACE;
         cfg_ff.repeat_space     <= RST_REPEAT_SPACE;
         cfg_ff.bit_mark         <= RST_BIT_MARK;
         cfg_ff.zero_space       <= RST_ZERO_SPACE;
         cfg_ff.one_space        <= RST_ONE_SPACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // symbol and result registers
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sym_fire  = sym_valid_ff && out_free;
   assign req_ready = !sym_valid_ff || out_free;

   always_comb begin
      sym_valid_in = sym_valid_ff;
      sym_in       = sym_ff;
      if (req_ready) begin
         sym_valid_in = req_valid;
         sym_in       = req_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (sym_fire && fout.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = fout.rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sym_valid_ff <= sym_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff <= sym_in;
      rsp_ff <= rsp_in;
   end

   necir_symbol_class u_class (
      .cfg (cfg_ff),
      .sym (sym_ff),
      .cls (cls)
   );

   necir_frame_ctrl #(
      .FIELD_BITS (FIELD_BITS)
   ) u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (sym_fire),
      .burst_start (sym_ff.burst_start),
      .cls         (cls),
      .fout        (fout)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_sym_hold: assert property (@(posedge clock) disable iff (reset)
      sym_valid_ff && !out_free |=> sym_valid_ff && $stable(sym_ff))
      else $error("symbol register changed while stalled");

   a_non_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_FRAME |->
         rsp_ff.address == '0 && rsp_ff.command == '0)
      else $error("non-frame result carries payload");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !sym_valid_ff)
      else $error("pipeline not empty after reset");
`endif

endmodule
